// ===== rtl/orle_pkg.sv =====
// ----------------------------------------------------------------------------
// orle_pkg: shared types and constants for the ordered record list engine
// Command and status codes, record layout, controller/datapath command bus.
// ----------------------------------------------------------------------------
package orle_pkg;

	localparam int Capacity = 16;
	localparam int IdxW     = $clog2(Capacity);
	localparam int CntW     = 8;

	typedef enum logic [2:0] {
		CMD_CLEAR    = 3'd0,
		CMD_INSERT   = 3'd1,
		CMD_SEARCH   = 3'd2,
		CMD_DELETE   = 3'd3,
		CMD_SORT_ASC = 3'd4,
		CMD_SORT_DSC = 3'd5,
		CMD_COUNT    = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_BADPOS = 3'd2;
	localparam logic [2:0] ST_DUP    = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;

	typedef struct packed {
		logic signed [31:0] key;
		logic [31:0]        price;
		logic [3:0]         month;
		logic [11:0]        year;
	} rec_t;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_READ,    // read entries at rd_a and rd_b (registered)
		OP_WRITE,   // write new record (wr_new) or read data a at wr_a
		OP_SWAP     // write at wr_a the other entry of the last read pair (rd_b data if wr_a is rd_a)
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [IdxW-1:0] rd_a;
		logic [IdxW-1:0] rd_b;
		logic [IdxW-1:0] wr_a;
		logic            wr_new;  // write the incoming record, else read data a
	} dp_cmd_t;

	typedef struct packed {
		rec_t rec_a;
		rec_t rec_b;
	} dp_sts_t;

endpackage

// ===== rtl/orle_if.sv =====
// ----------------------------------------------------------------------------
// orle_req_if / orle_rsp_if: valid/ready channels of the list engine
// ----------------------------------------------------------------------------
interface orle_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [31:0] record_key;
	logic [31:0]        price_value;
	logic [3:0]         expiry_month;
	logic [11:0]        expiry_year;
	logic [7:0]         insert_position;
	modport source (output valid, command, record_key, price_value, expiry_month,
		expiry_year, insert_position, input ready);
	modport sink (input valid, command, record_key, price_value, expiry_month,
		expiry_year, insert_position, output ready);
endinterface

interface orle_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] found_position;
	logic [7:0] count_above;
	logic [7:0] list_size;
	modport source (output valid, status, found_position, count_above, list_size,
		input ready);
	modport sink (input valid, status, found_position, count_above, list_size,
		output ready);
endinterface

// ===== rtl/orle_datapath.sv =====
// ----------------------------------------------------------------------------
// orle_datapath: record storage with two registered read ports, one write
// Swap writes the last read pair back crosswise, one entry per swap op.
// ----------------------------------------------------------------------------
module orle_datapath
	import orle_pkg::*;
(
	input  logic    clk,
	input  dp_cmd_t cmd,
	input  rec_t    new_rec,
	output dp_sts_t sts
);

	rec_t mem_q [Capacity];
	rec_t rd_a_q, rd_b_q;

	// storage and registered read data
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_READ: begin
				rd_a_q <= mem_q[cmd.rd_a];
				rd_b_q <= mem_q[cmd.rd_b];
			end
			OP_WRITE: begin
				mem_q[cmd.wr_a] <= cmd.wr_new ? new_rec : rd_a_q;
			end
			OP_SWAP: begin
				mem_q[cmd.wr_a] <= (cmd.wr_a == cmd.rd_a) ? rd_b_q : rd_a_q;
			end
			default: ;
		endcase
	end

	assign sts.rec_a = rd_a_q;
	assign sts.rec_b = rd_b_q;

endmodule

// ===== rtl/orle_ctrl.sv =====
// ----------------------------------------------------------------------------
// orle_ctrl: command sequencer for the list engine
// Walks entries one or two per step, drives the datapath, builds the result.
// ----------------------------------------------------------------------------
module orle_ctrl
	import orle_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	orle_req_if.sink   req,
	orle_rsp_if.source rsp,
	output dp_cmd_t dcmd,
	output rec_t    new_rec,
	input  dp_sts_t dsts
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_INS_RD, S_INS_WR, S_INS_NEW,
		S_DEL_RD, S_DEL_WR, S_SORT_RD, S_SORT_CHK, S_SORT_SW2, S_RESP
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	rec_t            rec_q;
	logic [7:0]      pos_q;
	logic [CntW-1:0] size_q;
	logic [CntW-1:0] i_q, j_q;     // walk indexes, wide enough to hold size
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] hit_q;        // 0-based index of match, size when absent
	logic [2:0]      status_q;
	logic [CntW-1:0] found_q;

	logic signed [31:0] ka, kb;
	logic               disorder;

	assign ka = dsts.rec_a.key;
	assign kb = dsts.rec_b.key;
	assign disorder = (cmd_q == CMD_SORT_DSC) ? (ka < kb) : (ka > kb);
	assign new_rec  = rec_q;

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = (state_q == S_RESP);
	assign rsp.status         = status_q;
	assign rsp.found_position = found_q;
	assign rsp.count_above    = cnt_q;
	assign rsp.list_size      = size_q;

	// datapath command decode
	always_comb begin
		dcmd = '{op: OP_IDLE, rd_a: i_q[IdxW-1:0], rd_b: j_q[IdxW-1:0],
			wr_a: i_q[IdxW-1:0], wr_new: 1'b0};
		unique case (state_q)
			S_SCAN_RD, S_DEL_RD, S_SORT_RD: dcmd.op = OP_READ;
			S_INS_RD: begin
				dcmd.op   = OP_READ;
				dcmd.rd_a = j_q[IdxW-1:0] - 1'b1;
			end
			S_INS_WR: dcmd.op = OP_WRITE;
			S_INS_NEW: begin
				dcmd.op     = OP_WRITE;
				dcmd.wr_new = 1'b1;
			end
			S_DEL_WR: begin
				dcmd.op   = OP_WRITE;
				dcmd.wr_a = i_q[IdxW-1:0] - 1'b1;
			end
			S_SORT_CHK: begin
				dcmd.op = disorder ? OP_SWAP : OP_IDLE;
			end
			S_SORT_SW2: begin
				dcmd.op   = OP_SWAP;
				dcmd.wr_a = j_q[IdxW-1:0];
			end
			default: ;
		endcase
		if (state_q == S_INS_WR) dcmd.wr_a = j_q[IdxW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			size_q   <= '0;
			status_q <= ST_OK;
			found_q  <= '0;
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			hit_q    <= '0;
			cmd_q    <= CMD_NOP;
			rec_q    <= '0;
			pos_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					cmd_q    <= cmd_t'(req.command);
					rec_q    <= '{key: req.record_key, price: req.price_value,
						month: req.expiry_month, year: req.expiry_year};
					pos_q    <= req.insert_position;
					status_q <= ST_OK;
					found_q  <= '0;
					cnt_q    <= '0;
					i_q      <= '0;
					j_q      <= '0;
					hit_q    <= size_q;
					unique case (cmd_t'(req.command))
						CMD_CLEAR: begin
							size_q  <= '0;
							state_q <= S_RESP;
						end
						CMD_INSERT, CMD_SEARCH, CMD_DELETE, CMD_COUNT:
							state_q <= (size_q == '0) ? S_SCAN_CHK : S_SCAN_RD;
						CMD_SORT_ASC, CMD_SORT_DSC: begin
							j_q     <= size_q - 1'b1;
							state_q <= (size_q < CntW'(2)) ? S_RESP : S_SORT_RD;
						end
						default: state_q <= S_RESP;
					endcase
				end
				// linear walk: entry i read, then compared
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (i_q < size_q) begin
						if (cmd_q == CMD_COUNT) begin
							if (dsts.rec_a.price > rec_q.price) cnt_q <= cnt_q + 1'b1;
						end else if (dsts.rec_a.key == rec_q.key && hit_q == size_q) begin
							hit_q <= i_q;
						end
					end
					if (i_q + 1'b1 < size_q && !(cmd_q != CMD_COUNT &&
							(hit_q != size_q || dsts.rec_a.key == rec_q.key))) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						logic [CntW-1:0] h;
						h = (i_q < size_q && hit_q == size_q &&
							dsts.rec_a.key == rec_q.key) ? i_q : hit_q;
						state_q <= S_RESP;
						unique case (cmd_q)
							CMD_SEARCH: begin
								if (h == size_q) status_q <= ST_ABSENT;
								else found_q <= h + 1'b1;
							end
							CMD_DELETE: begin
								if (h == size_q) status_q <= ST_ABSENT;
								else begin
									i_q     <= h + 1'b1;
									state_q <= S_DEL_RD;
								end
							end
							CMD_INSERT: begin
								if (h != size_q) status_q <= ST_DUP;
								else if (size_q >= CntW'(Capacity)) status_q <= ST_FULL;
								else if (pos_q == '0 || pos_q > size_q + 1'b1)
									status_q <= ST_BADPOS;
								else begin
									j_q     <= size_q;
									i_q     <= pos_q - 1'b1;
									state_q <= (size_q == pos_q - 1'b1) ? S_INS_NEW : S_INS_RD;
								end
							end
							default: ;
						endcase
					end
				end
				// insert: move entry j-1 to j, downward to the insert slot
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					j_q     <= j_q - 1'b1;
					state_q <= (j_q - 1'b1 == i_q) ? S_INS_NEW : S_INS_RD;
				end
				S_INS_NEW: begin
					size_q  <= size_q + 1'b1;
					state_q <= S_RESP;
				end
				// delete: move entry i to i-1 upward, shrink once the tail is moved
				S_DEL_RD: begin
					if (i_q < size_q) state_q <= S_DEL_WR;
					else begin
						size_q  <= size_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_DEL_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_DEL_RD;
				end
				// exchange sort: compare i with j, j from last down to i+1
				S_SORT_RD: state_q <= S_SORT_CHK;
				S_SORT_CHK: begin
					if (disorder) state_q <= S_SORT_SW2;
					else if (j_q - 1'b1 > i_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SORT_RD;
					end else if (i_q + CntW'(2) < size_q) begin
						i_q     <= i_q + 1'b1;
						j_q     <= size_q - 1'b1;
						state_q <= S_SORT_RD;
					end else state_q <= S_RESP;
				end
				S_SORT_SW2: begin
					if (j_q - 1'b1 > i_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SORT_RD;
					end else if (i_q + CntW'(2) < size_q) begin
						i_q     <= i_q + 1'b1;
						j_q     <= size_q - 1'b1;
						state_q <= S_SORT_RD;
					end else state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CntW'(Capacity)) else $error("list size above capacity");
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("accept while result pending");
	a_found_search: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && found_q != '0 |-> cmd_q == CMD_SEARCH)
		else $error("found position outside search");
`endif

endmodule

// ===== rtl/ordered_record_list_engine.sv =====
// Clear empties the list; search, delete and insert walk the list entry by entry
// up to a key match, count walks every entry; insert and delete then shift the
// entries behind the slot one at a time; sort compares pairs, swaps those out of order.
// One command in flight at a time; the result is held until taken.
// Reset (arst_n low) empties the list; record storage is not cleared.
// ----------------------------------------------------------------------------
// ordered_record_list_engine: packed record list with insert, delete, search, count, sort
// Sequencer in orle_ctrl, storage in orle_datapath.
// ----------------------------------------------------------------------------
module ordered_record_list_engine
	import orle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	orle_req_if.sink   req,
	orle_rsp_if.source rsp
);

	dp_cmd_t dcmd;
	dp_sts_t dsts;
	rec_t    new_rec;

	orle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.dcmd   (dcmd),
		.new_rec(new_rec),
		.dsts   (dsts)
	);

	orle_datapath u_dp (
		.clk    (clk),
		.cmd    (dcmd),
		.new_rec(new_rec),
		.sts    (dsts)
	);

endmodule
